// ----- rtl/core/tce_pkg.sv -----
`timescale 1ns / 1ps

package tce_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Fixed field widths of the stream words.
  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int CELL_W   = 16;
  localparam int TCOL_W   = 7;
  localparam int TROW_W   = 5;
  localparam int POS_W    = 11;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR     = 3'd0,
    CMD_PUT_AT       = 3'd1,
    CMD_SET_CURSOR   = 3'd2,
    CMD_CLEAR_SCREEN = 3'd3,
    CMD_CLEAR_ROW    = 3'd4,
    CMD_READ_CELL    = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_entry;
    logic [TCOL_W-1:0] cursor_col;
    logic [TROW_W-1:0] cursor_row;
    logic [POS_W-1:0]  cursor_pos;
    logic              cursor_update;
  } result_t;

endpackage

// ----- rtl/core/tce_ram.sv -----
`timescale 1ns / 1ps

module tce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/tce_ctrl.sv -----
`timescale 1ns / 1ps

module tce_ctrl
  import tce_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [COLOR_W-1:0]               cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cmd_t                             in_cmd,
  input  logic [CHAR_W-1:0]                in_char,
  input  logic [TCOL_W-1:0]                in_col,
  input  logic [TROW_W-1:0]                in_row,
  output logic                             res_valid,
  input  logic                             res_ready,
  output result_t                          res,
  output logic                             mem_wr_en,
  output logic [$clog2(COLUMNS*ROWS)-1:0]  mem_wr_addr,
  output logic [CELL_W-1:0]                mem_wr_data,
  output logic                             mem_rd_en,
  output logic [$clog2(COLUMNS*ROWS)-1:0]  mem_rd_addr,
  input  logic [CELL_W-1:0]                mem_rd_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CALC_W = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] FIRST_SRC   = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_READ, ST_COPY, ST_DRAIN, ST_FILL, ST_DONE
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  state_t              state_r, state_nxt;
  logic [COLOR_W-1:0]  text_color_r, text_color_nxt;
  logic [COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]    cur_row_r, cur_row_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic [TCOL_W-1:0]   tcol_r, tcol_nxt;
  logic [TROW_W-1:0]   trow_r, trow_nxt;
  logic [CELL_W-1:0]   cell_r, cell_nxt;
  logic                upd_r, upd_nxt;
  logic [ADDR_W-1:0]   fill_ptr_r, fill_ptr_nxt;
  logic [ADDR_W-1:0]   fill_end_r, fill_end_nxt;
  logic [ADDR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic                pipe_vld_r, pipe_vld_nxt;

  logic [CELL_W-1:0]   blank;
  logic [ADDR_W-1:0]   cur_addr;
  logic [ADDR_W-1:0]   tgt_addr;
  logic [ADDR_W-1:0]   row_base;
  logic                tcol_ok;
  logic                trow_ok;
  logic                accept;

  assign blank    = {text_color_r, SPACE_CHAR};
  assign cur_addr = cell_addr(cur_row_r, cur_col_r);
  assign tcol_ok  = int'(tcol_r) < COLUMNS;
  assign trow_ok  = int'(trow_r) < ROWS;
  assign tgt_addr = cell_addr(ROW_W'(trow_r), COL_W'(tcol_r));
  assign row_base = cell_addr(ROW_W'(trow_r), '0);

  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_DONE) && res_ready);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_DONE);

  assign res.cell_entry    = cell_r;
  assign res.cursor_col    = TCOL_W'(cur_col_r);
  assign res.cursor_row    = TROW_W'(cur_row_r);
  assign res.cursor_pos    = POS_W'(CALC_W'(cur_row_r) * CALC_W'(COLUMNS) + CALC_W'(cur_col_r));
  assign res.cursor_update = upd_r;

  always_comb begin
    state_nxt      = state_r;
    text_color_nxt = cfg_wr_en ? cfg_wr_data : text_color_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    cmd_nxt        = cmd_r;
    char_nxt       = char_r;
    tcol_nxt       = tcol_r;
    trow_nxt       = trow_r;
    cell_nxt       = cell_r;
    upd_nxt        = upd_r;
    fill_ptr_nxt   = fill_ptr_r;
    fill_end_nxt   = fill_end_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    pipe_vld_nxt   = pipe_vld_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = cur_addr;
    mem_wr_data    = {text_color_r, char_r};
    mem_rd_en      = 1'b0;
    mem_rd_addr    = tgt_addr;

    case (state_r)
      ST_INIT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = fill_ptr_r;
        mem_wr_data = RESET_CELL;
        fill_ptr_nxt = fill_ptr_r + 1'b1;
        if (fill_ptr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_EXEC: begin
        cell_nxt     = '0;
        upd_nxt      = 1'b0;
        pipe_vld_nxt = 1'b0;
        state_nxt    = ST_DONE;
        case (cmd_r)
          CMD_PUT_CHAR: begin
            // A character written in the last column moves the cursor to column 1 of the next row.
            if (char_r == NEWLINE_CHAR || cur_col_r == LAST_COL) begin
              cur_col_nxt = (char_r == NEWLINE_CHAR) ? '0 : COL_W'(1);
              if (cur_row_r == LAST_ROW) begin
                rd_ptr_nxt = FIRST_SRC;
                state_nxt  = ST_COPY;
              end else begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
            end else begin
              cur_col_nxt = cur_col_r + 1'b1;
            end
            if (char_r != NEWLINE_CHAR) begin
              mem_wr_en = 1'b1;
              upd_nxt   = 1'b1;
            end
          end
          CMD_PUT_AT: begin
            mem_wr_en   = tcol_ok && trow_ok;
            mem_wr_addr = tgt_addr;
          end
          CMD_SET_CURSOR: begin
            cur_col_nxt = tcol_ok ? COL_W'(tcol_r) : LAST_COL;
            cur_row_nxt = trow_ok ? ROW_W'(trow_r) : LAST_ROW;
            upd_nxt     = 1'b1;
          end
          CMD_CLEAR_SCREEN: begin
            cur_col_nxt  = '0;
            cur_row_nxt  = '0;
            fill_ptr_nxt = '0;
            fill_end_nxt = LAST_CELL;
            state_nxt    = ST_FILL;
          end
          CMD_CLEAR_ROW: begin
            if (tcol_ok && trow_ok) begin
              fill_ptr_nxt = tgt_addr;
              fill_end_nxt = row_base + ADDR_W'(COLUMNS - 1);
              state_nxt    = ST_FILL;
            end
          end
          CMD_READ_CELL: begin
            if (tcol_ok && trow_ok) begin
              mem_rd_en = 1'b1;
              state_nxt = ST_READ;
            end
          end
          default: begin
          end
        endcase
      end

      ST_READ: begin
        cell_nxt  = mem_rd_data;
        state_nxt = ST_DONE;
      end

      // Scroll: each cell is read one row below and its registered read data is written
      // back, so the write pointer trails the read pointer by a full row and one cell.
      ST_COPY: begin
        mem_rd_en    = 1'b1;
        mem_rd_addr  = rd_ptr_r;
        mem_wr_en    = pipe_vld_r;
        mem_wr_addr  = wr_ptr_r;
        mem_wr_data  = mem_rd_data;
        pipe_vld_nxt = 1'b1;
        wr_ptr_nxt   = rd_ptr_r - FIRST_SRC;
        rd_ptr_nxt   = rd_ptr_r + 1'b1;
        if (rd_ptr_r == LAST_CELL) begin
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = wr_ptr_r;
        mem_wr_data  = mem_rd_data;
        fill_ptr_nxt = BOTTOM_BASE;
        fill_end_nxt = LAST_CELL;
        state_nxt    = ST_FILL;
      end

      ST_FILL: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = fill_ptr_r;
        mem_wr_data  = blank;
        fill_ptr_nxt = fill_ptr_r + 1'b1;
        if (fill_ptr_r == fill_end_r) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
      end
    endcase

    if (accept) begin
      cmd_nxt   = in_cmd;
      char_nxt  = in_char;
      tcol_nxt  = in_col;
      trow_nxt  = in_row;
      state_nxt = ST_EXEC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      text_color_r <= RESET_COLOR;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      fill_ptr_r   <= '0;
      pipe_vld_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      text_color_r <= text_color_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      fill_ptr_r   <= fill_ptr_nxt;
      pipe_vld_r   <= pipe_vld_nxt;
    end
    cmd_r      <= cmd_nxt;
    char_r     <= char_nxt;
    tcol_r     <= tcol_nxt;
    trow_r     <= trow_nxt;
    cell_r     <= cell_nxt;
    upd_r      <= upd_nxt;
    fill_end_r <= fill_end_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
  end

endmodule

// ----- rtl/core/text_console_writer.sv -----
`timescale 1ns / 1ps

// Text console writer. The screen of ROWS x COLUMNS 16-bit cells (attribute in
// the high byte, character in the low byte) lives in one RAM with one write
// and one registered read port; the cursor and text color live in registers.
// After reset the block runs a clearing pass that fills every cell with
// 0x0720, and holds in_tready low until it is done; cfg writes are taken at
// any time. Put char, put at cell and set cursor are carried out in the
// execute state; the result then waits in the done state until the output
// register takes it, and the next word is accepted at the same time. Read
// cell passes through a read state for the registered RAM read when the cell
// is on screen. Clear screen and clear row have one cell written per cycle.
// A put char that moves past the last row scrolls: every cell above the
// bottom row is copied one per cycle through the RAM's read and write ports,
// then the bottom row is blanked.
module text_console_writer
  import tce_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,  // text_color
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // char_code[7:0], target_col[14:8], target_row[19:15]
  input  logic [2:0]  in_tuser,     // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // cell_entry[15:0], cursor_col[22:16],
                                    // cursor_row[27:23], cursor_pos[38:28]
  output logic [0:0]  out_tuser     // cursor_update[0]
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [CELL_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [CELL_W-1:0] mem_rd_data;

  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;

  tce_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (cmd_t'(in_tuser)),
    .in_char     (in_tdata[7:0]),
    .in_col      (in_tdata[14:8]),
    .in_row      (in_tdata[19:15]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  tce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.cursor_pos, out_res_r.cursor_row,
                       out_res_r.cursor_col, out_res_r.cell_entry};
  assign out_tuser  = out_res_r.cursor_update;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_res_r.cursor_col) < COLUMNS))
    else $error("result cursor column beyond screen width");

  a_res_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result changed before the output register took it");

  a_out_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(res_valid))
    else $error("output word appeared without a result from the controller");

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |-> !in_tready)
    else $error("input accepted while the previous result is still pending");

endmodule
